/* hdl/avt_pkg.sv */
// shared types and constants for the affine vertex transform
package avt_pkg;

    localparam int WORD_W           = 32;
    localparam int SEL_W            = 6;
    localparam int ADDR_W           = 10;
    localparam int WORDS_PER_MATRIX = 'h10;
    localparam int COEF_IDX_W       = 4;
    localparam int NUM_BANKS        = 12;   // 3x3 part plus translation
    localparam int NUM_VECS         = 3;    // position, vector a, vector b
    localparam int NUM_COMP         = 3;

    // coefficient indexes of the translation column
    localparam logic [COEF_IDX_W-1:0] COEF_TRANS_X = 4'hc;
    localparam logic [COEF_IDX_W-1:0] COEF_TRANS_Y = 4'hd;
    localparam logic [COEF_IDX_W-1:0] COEF_TRANS_Z = 4'he;
    localparam int TRANS_BANK = 9;

    localparam int PALETTE_ENTRIES_DEF = 64;
    localparam int FRAC_BITS_DEF       = 16;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } avt_op_t;

    typedef struct packed {
        avt_op_t                  opcode;
        logic [ADDR_W-1:0]        load_address;
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] vec_a_x;
        logic signed [WORD_W-1:0] vec_a_y;
        logic signed [WORD_W-1:0] vec_a_z;
        logic signed [WORD_W-1:0] vec_b_x;
        logic signed [WORD_W-1:0] vec_b_y;
        logic signed [WORD_W-1:0] vec_b_z;
        logic                     last_vertex;
    } avt_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_pos_x;
        logic signed [WORD_W-1:0] out_pos_y;
        logic signed [WORD_W-1:0] out_pos_z;
        logic signed [WORD_W-1:0] out_a_x;
        logic signed [WORD_W-1:0] out_a_y;
        logic signed [WORD_W-1:0] out_a_z;
        logic signed [WORD_W-1:0] out_b_x;
        logic signed [WORD_W-1:0] out_b_y;
        logic signed [WORD_W-1:0] out_b_z;
        logic                     overflow;
        logic                     last_out;
    } avt_out_t;

    // palette access request, one per accepted beat
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } avt_mem_req_t;

    // bank b = 3*row + column, row 3 is the translation
    typedef struct packed {
        logic [NUM_BANKS-1:0][WORD_W-1:0] w;
    } avt_coef_t;

    typedef logic [NUM_VECS-1:0][NUM_COMP-1:0][WORD_W-1:0] avt_vec_set_t;

endpackage

/* hdl/avt_in_if.sv */
// input channel: vertex records and palette loads
interface avt_in_if;
    logic             valid;
    logic             ready;
    avt_pkg::avt_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/avt_out_if.sv */
// output channel: transformed vertex records
interface avt_out_if;
    logic              valid;
    logic              ready;
    avt_pkg::avt_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/avt_palette.sv */
// matrix palette: one synchronous bank per used coefficient
module avt_palette #(
    parameter int PALETTE_ENTRIES = avt_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  avt_pkg::avt_mem_req_t             req,
    input  logic [avt_pkg::SEL_W-1:0]         sel,
    output avt_pkg::avt_coef_t                coef
);
    import avt_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int DEPTH = PALETTE_ENTRIES * WORDS_PER_MATRIX;

    logic                 addr_ok;
    logic                 sel_ok;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     rd_idx;
    logic [NUM_BANKS-1:0] wr_hit;
    logic [WORD_W-1:0]    rdata_reg [NUM_BANKS];
    logic                 sel_ok_reg;

    assign addr_ok = 32'(req.addr) < 32'(DEPTH);
    assign sel_ok  = 32'(sel) < 32'(PALETTE_ENTRIES);
    assign wr_idx  = IDX_W'(req.addr >> COEF_IDX_W);
    assign rd_idx  = IDX_W'(sel);

    // word 3 of each row is never read, so it gets no bank
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                wr_hit[3*j + c] = req.wr_en && addr_ok
                                  && (req.addr[3:2] == 2'(j))
                                  && (req.addr[1:0] == 2'(c));
            end
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [WORD_W-1:0] mem [PALETTE_ENTRIES];

        always_ff @(posedge clk)
        begin
            if (wr_hit[b])
            begin
                mem[wr_idx] <= req.wdata;
            end
            if (req.rd_en)
            begin
                rdata_reg[b] <= mem[rd_idx];
            end
        end

        // selection beyond the palette reads as zero
        assign coef.w[b] = sel_ok_reg ? rdata_reg[b] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            sel_ok_reg <= sel_ok;
        end
    end

endmodule

/* hdl/avt_datapath.sv */
// multiply, sum and saturate pipeline with its output register
module avt_datapath #(
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  avt_pkg::avt_vec_set_t vec_in,
    input  logic                  last_in,
    input  avt_pkg::avt_coef_t    coef,
    output logic                  ready,
    avt_out_if.source             res
);
    import avt_pkg::*;

    localparam int PROD_W = 2*WORD_W - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;

    logic rdy1, rdy2, rdy3, rdy4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg;

    avt_vec_set_t vec1_reg;

    logic signed [2*WORD_W-1:0] prod_full [NUM_VECS][NUM_COMP][NUM_COMP];
    logic signed [PROD_W-1:0]   prod2_reg [NUM_VECS][NUM_COMP][NUM_COMP];
    logic signed [WORD_W-1:0]   trans2_reg [NUM_COMP];
    logic signed [SUM_W-1:0]    sum_next  [NUM_VECS][NUM_COMP];
    logic signed [SUM_W-1:0]    sum3_reg  [NUM_VECS][NUM_COMP];
    logic [WORD_W-1:0]          sat_next  [NUM_VECS][NUM_COMP];
    logic [NUM_VECS*NUM_COMP-1:0] clip_next;
    logic [WORD_W-1:0]          sat4_reg  [NUM_VECS][NUM_COMP];
    logic                       ovf4_reg;

    // bubbles collapse, a stage moves when the one after it can take it
    assign rdy4  = !v4_reg || res.ready;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= start;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // coefficient m[4i+c] sits in bank 3i+c
    always_comb
    begin
        for (int r = 0; r < NUM_VECS; r++)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                for (int i = 0; i < NUM_COMP; i++)
                begin
                    prod_full[r][c][i] = $signed(vec1_reg[r][i]) * $signed(coef.w[3*i + c]);
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_VECS; r++)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                sum_next[r][c] = SUM_W'(prod2_reg[r][c][0]) + SUM_W'(prod2_reg[r][c][1])
                               + SUM_W'(prod2_reg[r][c][2])
                               + ((r == 0) ? SUM_W'(trans2_reg[c]) : SUM_W'(0));
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_VECS; r++)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                clip_next[3*r + c] = !((&sum3_reg[r][c][SUM_W-1:WORD_W-1])
                                     || !(|sum3_reg[r][c][SUM_W-1:WORD_W-1]));
                if (!clip_next[3*r + c])
                begin
                    sat_next[r][c] = sum3_reg[r][c][WORD_W-1:0];
                end
                else if (sum3_reg[r][c][SUM_W-1])
                begin
                    sat_next[r][c] = {1'b1, {(WORD_W-1){1'b0}}};
                end
                else
                begin
                    sat_next[r][c] = {1'b0, {(WORD_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && start)
        begin
            vec1_reg  <= vec_in;
            last1_reg <= last_in;
        end
        if (rdy2 && v1_reg)
        begin
            for (int r = 0; r < NUM_VECS; r++)
            begin
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    for (int i = 0; i < NUM_COMP; i++)
                    begin
                        // floor of the product by dropping fraction bits
                        prod2_reg[r][c][i] <= prod_full[r][c][i][2*WORD_W-1:FRAC_BITS];
                    end
                end
            end
            for (int c = 0; c < NUM_COMP; c++)
            begin
                trans2_reg[c] <= coef.w[TRANS_BANK + c];
            end
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sum3_reg  <= sum_next;
            last3_reg <= last2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            sat4_reg  <= sat_next;
            ovf4_reg  <= |clip_next;
            last4_reg <= last3_reg;
        end
    end

    assign res.valid          = v4_reg;
    assign res.data.out_pos_x = sat4_reg[0][0];
    assign res.data.out_pos_y = sat4_reg[0][1];
    assign res.data.out_pos_z = sat4_reg[0][2];
    assign res.data.out_a_x   = sat4_reg[1][0];
    assign res.data.out_a_y   = sat4_reg[1][1];
    assign res.data.out_a_z   = sat4_reg[1][2];
    assign res.data.out_b_x   = sat4_reg[2][0];
    assign res.data.out_b_y   = sat4_reg[2][1];
    assign res.data.out_b_z   = sat4_reg[2][2];
    assign res.data.overflow  = ovf4_reg;
    assign res.data.last_out  = last4_reg;

endmodule

/* hdl/affine_vertex_transform_top.sv */
// top level of the affine vertex transform
//
//   channel  dir  beat
//   vtx      in   palette word load or vertex record
//   res      out  transformed vertex record, one per vertex record
//   cfg      in   palette_select write, cfg_we with cfg_wdata
//
// one beat per cycle in and out while res is not stalled; a vertex result is
// registered through the palette read, multiply, sum and saturate stages
// a load is written into the palette banks at the edge it is taken, no result
// reset clears the stage valids and palette_select, not the palette words
// a stall on res holds the full stages, empty stages still fill; the input
// waits once all four stages are full
module affine_vertex_transform_top #(
    parameter int PALETTE_ENTRIES = avt_pkg::PALETTE_ENTRIES_DEF,
    parameter int FRAC_BITS       = avt_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    avt_in_if.sink                    vtx,
    avt_out_if.source                 res,
    input  logic                      cfg_we,
    input  logic [avt_pkg::SEL_W-1:0] cfg_wdata
);
    import avt_pkg::*;

    logic [SEL_W-1:0] palette_select_reg;
    logic             dp_ready;
    logic             beat;
    logic             start;
    avt_mem_req_t     mem_req;
    avt_coef_t        coef;
    avt_vec_set_t     vec_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_select_reg <= '0;
        end
        else if (cfg_we)
        begin
            palette_select_reg <= cfg_wdata;
        end
    end

    assign vtx.ready = dp_ready;
    assign beat      = vtx.valid && dp_ready;
    assign start     = beat && (vtx.data.opcode == OP_XFORM);

    assign mem_req.wr_en = beat && (vtx.data.opcode == OP_LOAD);
    assign mem_req.rd_en = start;
    assign mem_req.addr  = vtx.data.load_address;
    assign mem_req.wdata = vtx.data.pos_x;

    assign vec_in[0][0] = vtx.data.pos_x;
    assign vec_in[0][1] = vtx.data.pos_y;
    assign vec_in[0][2] = vtx.data.pos_z;
    assign vec_in[1][0] = vtx.data.vec_a_x;
    assign vec_in[1][1] = vtx.data.vec_a_y;
    assign vec_in[1][2] = vtx.data.vec_a_z;
    assign vec_in[2][0] = vtx.data.vec_b_x;
    assign vec_in[2][1] = vtx.data.vec_b_y;
    assign vec_in[2][2] = vtx.data.vec_b_z;

    avt_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk  (clk),
        .req  (mem_req),
        .sel  (palette_select_reg),
        .coef (coef)
    );

    avt_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .vec_in  (vec_in),
        .last_in (vtx.data.last_vertex),
        .coef    (coef),
        .ready   (dp_ready),
        .res     (res)
    );

endmodule
